@@ design/set_pkg.sv @@
// Shared types and constants for the Sobel edge threshold unit.
// No dependencies; all other design files but set_line_mem refer to it by scoped names.
package set_pkg;

    typedef logic [7:0] pixel_t;
    typedef logic [7:0] pos_t;

    typedef enum logic [1:0] {
        CFG_FRAME_ROWS     = 2'd0,
        CFG_ROW_LENGTH     = 2'd1,
        CFG_EDGE_THRESHOLD = 2'd2
    } cfg_idx_t;

    localparam pos_t   MIN_SIZE       = 8'd3;
    localparam pos_t   RST_FRAME_ROWS = 8'd255;
    localparam pos_t   RST_ROW_LENGTH = 8'd255;
    localparam pixel_t RST_THRESHOLD  = 8'd100;
    localparam int     FIFO_DEPTH     = 4;

    typedef struct packed {
        logic   valid;
        logic   interior;
        logic   border;
        logic   last;
        logic   in_depth;
        logic   border_edge;
        pos_t   row;
        pos_t   col;
        pixel_t pixel;
    } tap_t;

    typedef struct packed {
        pos_t row;
        pos_t col;
        logic edge_res;
        logic frame_end;
    } res_t;

    typedef struct packed {
        logic v0;
        logic v1;
        res_t r0;
        res_t r1;
    } push_t;

endpackage

@@ design/set_if.sv @@
// Request channel interfaces: pixel input and classified result output.
// Depends on set_pkg.
interface set_pix_if;
    logic              valid;
    logic              ready;
    set_pkg::pixel_t   pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface set_res_if;
    logic              valid;
    logic              ready;
    set_pkg::pos_t     out_row;
    set_pkg::pos_t     out_col;
    logic              edge_res;
    logic              frame_end;

    modport source (output valid, output out_row, output out_col, output edge_res,
                    output frame_end, input ready);
    modport sink   (input valid, input out_row, input out_col, input edge_res,
                    input frame_end, output ready);
endinterface

@@ design/set_line_mem.sv @@
// Two-row line store: one synchronous memory, word = {row two above, row above}.
// One write port, one read port, registered read data. No package dependency.
module set_line_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

`ifndef SYNTHESIS
    a_no_same_addr: assert property (@(posedge clk)
        !(rd_en && wr_en && rd_addr == wr_addr))
        else $error("line store read and write hit the same column");
`endif

endmodule

@@ design/set_grad.sv @@
// Window shift, Sobel gradients, squared magnitude and threshold compare.
// Registered gradient and square stages after the line store read; depends on set_pkg.
module set_grad (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  set_pkg::tap_t  tap,
    input  logic [15:0]    line_rd,
    input  logic [15:0]    thr_sq,
    output logic           line_we,
    output logic [15:0]    line_wd,
    output set_pkg::push_t push
);

    typedef struct packed {
        logic          valid;
        logic          interior;
        logic          border;
        logic          last;
        logic          border_edge;
        set_pkg::pos_t row;
        set_pkg::pos_t col;
    } ctl_t;

    set_pkg::pixel_t    win_reg [6];
    set_pkg::pixel_t    top;
    set_pkg::pixel_t    mid;
    logic [9:0]         sum_r;
    logic [9:0]         sum_l;
    logic [9:0]         sum_b;
    logic [9:0]         sum_t;
    logic signed [10:0] gx_next;
    logic signed [10:0] gy_next;
    logic signed [10:0] gx_reg;
    logic signed [10:0] gy_reg;
    logic signed [21:0] prod_x;
    logic signed [21:0] prod_y;
    logic [19:0]        sq_x_reg;
    logic [19:0]        sq_y_reg;
    logic [20:0]        mag2;
    logic               grad_edge;
    ctl_t               s2_reg;
    ctl_t               s3_reg;
    ctl_t               s2_next;
    set_pkg::res_t      res_in;
    set_pkg::res_t      res_bd;

    assign top = tap.in_depth ? line_rd[15:8] : '0;
    assign mid = tap.in_depth ? line_rd[7:0]  : '0;

    assign line_we = adv && tap.valid && tap.in_depth;
    assign line_wd = {mid, tap.pixel};

    // window columns: left = win 0..2, middle = win 3..5, right = top/mid/pixel
    assign sum_r = {2'b0, top} + {1'b0, mid, 1'b0} + {2'b0, tap.pixel};
    assign sum_l = {2'b0, win_reg[0]} + {1'b0, win_reg[1], 1'b0} + {2'b0, win_reg[2]};
    assign sum_b = {2'b0, win_reg[2]} + {1'b0, win_reg[5], 1'b0} + {2'b0, tap.pixel};
    assign sum_t = {2'b0, win_reg[0]} + {1'b0, win_reg[3], 1'b0} + {2'b0, top};
    assign gx_next = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
    assign gy_next = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});

    assign s2_next = '{valid:       tap.valid,
                       interior:    tap.interior,
                       border:      tap.border,
                       last:        tap.last,
                       border_edge: tap.border_edge,
                       row:         tap.row,
                       col:         tap.col};

    assign prod_x = gx_reg * gx_reg;
    assign prod_y = gy_reg * gy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else if (adv)
        begin
            if (tap.valid)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top;
                win_reg[4] <= mid;
                win_reg[5] <= tap.pixel;
            end
            s2_reg <= s2_next;
            s3_reg <= s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gx_reg   <= gx_next;
            gy_reg   <= gy_next;
            sq_x_reg <= prod_x[19:0];
            sq_y_reg <= prod_y[19:0];
        end
    end

    assign mag2      = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign grad_edge = mag2 >= {5'b0, thr_sq};

    assign res_in = '{row:       s3_reg.row - 8'd1,
                      col:       s3_reg.col - 8'd1,
                      edge_res:  grad_edge,
                      frame_end: 1'b0};
    assign res_bd = '{row:       s3_reg.row,
                      col:       s3_reg.col,
                      edge_res:  s3_reg.border_edge,
                      frame_end: s3_reg.last};

    always_comb
    begin
        push    = '0;
        push.r0 = s3_reg.interior ? res_in : res_bd;
        push.r1 = res_bd;
        if (adv && s3_reg.valid)
        begin
            push.v0 = s3_reg.interior || s3_reg.border;
            push.v1 = s3_reg.interior && s3_reg.border;
        end
    end

endmodule

@@ design/set_res_fifo.sv @@
// Result queue: takes up to two results per cycle, hands out one per request.
// Depends on set_pkg and set_res_if.
module set_res_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  set_pkg::push_t  push,
    output logic            room,
    set_res_if.source       results
);

    localparam int PW = $clog2(set_pkg::FIFO_DEPTH);
    localparam int CW = $clog2(set_pkg::FIFO_DEPTH + 1);

    set_pkg::res_t  entry_reg [set_pkg::FIFO_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           pop;
    logic [PW-1:0]  wr_ptr_b;
    set_pkg::res_t  head;

    assign head              = entry_reg[rd_ptr_reg];
    assign results.valid     = count_reg != '0;
    assign results.out_row   = head.row;
    assign results.out_col   = head.col;
    assign results.edge_res  = head.edge_res;
    assign results.frame_end = head.frame_end;

    assign pop      = results.valid && results.ready;
    assign room     = count_reg <= CW'(set_pkg::FIFO_DEPTH - 2);
    assign wr_ptr_b = wr_ptr_reg + PW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.v0) + PW'(push.v1);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(push.v0) + CW'(push.v1) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            entry_reg[wr_ptr_b] <= push.r1;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(set_pkg::FIFO_DEPTH))
        else $error("result queue overflow");
    a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.v1 |-> push.v0)
        else $error("second result pushed without first");
`endif

endmodule

@@ design/sobel_edge_threshold_unit.sv @@
// Top level of the streaming 3x3 Sobel edge threshold unit.
// Depends on set_pkg, set_if, set_line_mem, set_grad and set_res_fifo.
//
//  channel   | direction | payload                               | handshake
//  ----------+-----------+---------------------------------------+------------
//  pixels    | in        | pixel[7:0]                            | valid/ready
//  results   | out       | out_row, out_col, edge_res, frame_end | valid/ready
//  cfg       | in        | cfg_index[1:0], cfg_data[7:0]         | cfg_wr_en
//
//  One pixel per cycle while pixels.ready is high; results pass the tap, gradient and square registers, then the queue.
//  Line store read in the accept cycle, write-back from the tap register when the pipeline advances.
//  pixels.ready follows the result queue fill only: low when fewer than two
//  slots are free. The whole pipeline holds while it is low.
//  Reset clears position, window and queue and loads default configuration; line store is not cleared.
module sobel_edge_threshold_unit #(
    parameter int LINE_DEPTH = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    set_pix_if.sink       pixels,
    set_res_if.source     results,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data
);

    localparam int AW = $clog2(LINE_DEPTH);

    set_pkg::pos_t   frame_rows_reg;
    set_pkg::pos_t   row_length_reg;
    set_pkg::pixel_t threshold_reg;
    logic [15:0]     thr_sq_reg;
    set_pkg::pos_t   row_pos_reg;
    set_pkg::pos_t   row_pos_next;
    set_pkg::pos_t   col_pos_reg;
    set_pkg::pos_t   col_pos_next;
    set_pkg::tap_t   tap_reg;
    set_pkg::tap_t   tap_next;
    set_pkg::pos_t   nrows;
    set_pkg::pos_t   ncols;
    logic            last_row;
    logic            last_col;
    logic            adv;
    logic            accept;
    logic [15:0]     line_rd;
    logic            line_we;
    logic [15:0]     line_wd;
    set_pkg::push_t  push;
    logic            room;

    assign adv           = room;
    assign pixels.ready  = adv;
    assign accept        = pixels.valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg <= set_pkg::RST_FRAME_ROWS;
            row_length_reg <= set_pkg::RST_ROW_LENGTH;
            threshold_reg  <= set_pkg::RST_THRESHOLD;
            thr_sq_reg     <= 16'(set_pkg::RST_THRESHOLD) * 16'(set_pkg::RST_THRESHOLD);
        end
        else
        begin
            thr_sq_reg <= 16'(threshold_reg) * 16'(threshold_reg);
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    set_pkg::CFG_FRAME_ROWS:     frame_rows_reg <= cfg_data;
                    set_pkg::CFG_ROW_LENGTH:     row_length_reg <= cfg_data;
                    set_pkg::CFG_EDGE_THRESHOLD: threshold_reg  <= cfg_data;
                    default:                     ;
                endcase
            end
        end
    end

    assign nrows    = (frame_rows_reg < set_pkg::MIN_SIZE) ? set_pkg::MIN_SIZE
                                                           : frame_rows_reg;
    assign ncols    = (row_length_reg < set_pkg::MIN_SIZE) ? set_pkg::MIN_SIZE
                                                           : row_length_reg;
    assign last_row = ({1'b0, row_pos_reg} + 9'd1) >= {1'b0, nrows};
    assign last_col = ({1'b0, col_pos_reg} + 9'd1) >= {1'b0, ncols};

    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg + 8'd1;
        if (last_col)
        begin
            col_pos_next = '0;
            row_pos_next = last_row ? '0 : row_pos_reg + 8'd1;
        end

        tap_next.valid       = accept;
        tap_next.interior    = (row_pos_reg >= 8'd2) && (col_pos_reg >= 8'd2);
        tap_next.border      = (row_pos_reg == '0) || last_row ||
                               (col_pos_reg == '0) || last_col;
        tap_next.last        = last_row && last_col;
        tap_next.in_depth    = int'(col_pos_reg) < LINE_DEPTH;
        tap_next.border_edge = pixels.pixel >= threshold_reg;
        tap_next.row         = row_pos_reg;
        tap_next.col         = col_pos_reg;
        tap_next.pixel       = pixels.pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            tap_reg     <= '0;
        end
        else if (adv)
        begin
            tap_reg <= tap_next;
            if (accept)
            begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
            end
        end
    end

    set_line_mem #(
        .DEPTH (LINE_DEPTH)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept && tap_next.in_depth),
        .rd_addr (AW'(col_pos_reg)),
        .rd_data (line_rd),
        .wr_en   (line_we),
        .wr_addr (AW'(tap_reg.col)),
        .wr_data (line_wd)
    );

    set_grad u_grad (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tap     (tap_reg),
        .line_rd (line_rd),
        .thr_sq  (thr_sq_reg),
        .line_we (line_we),
        .line_wd (line_wd),
        .push    (push)
    );

    set_res_fifo u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .room    (room),
        .results (results)
    );

`ifndef SYNTHESIS
    a_accept_taps: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid && pixels.ready |=> tap_reg.valid)
        else $error("accepted pixel not captured");
    a_hold_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |-> !push.v0)
        else $error("result pushed while pipeline held");
`endif

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for sobel_edge_threshold_unit: directed table, then random frames,
// each result checked against the table or a Sobel classifier kept in step with the block.
// Depends on set_pkg, set_if and the design under design/.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 1150;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;
    localparam int SEND_IDLE [3] = '{30, 49, 0};
    localparam int RECV_IDLE [3] = '{49, 30, 0};

    typedef enum logic {
        STEP_PIXEL,
        STEP_WRITE
    } step_kind_t;

    typedef struct packed {
        step_kind_t        kind;
        set_pkg::cfg_idx_t sel;
        logic [7:0]        value;
        logic              typed;
        set_pkg::res_t     want;
    } stim_row_t;

    localparam set_pkg::res_t NO_RES    = '0;
    localparam int            DIR_COUNT = 26;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    set_pix_if pix ();
    set_res_if res ();

    sobel_edge_threshold_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix),
        .results   (res),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    set_pkg::pixel_t one_above [256];
    set_pkg::pixel_t two_above [256];
    set_pkg::pixel_t win [6];
    set_pkg::pos_t   scan_row;
    set_pkg::pos_t   scan_col;
    logic [7:0]      rows_q;
    logic [7:0]      cols_q;
    logic [7:0]      thresh_q;

    set_pkg::res_t classified_q [$];
    int            pixels_sent;
    int            idle_stage;
    int            mismatch_count;
    int            stall_cycles;

    stim_row_t directed_rows [DIR_COUNT] = '{
        '{STEP_WRITE, set_pkg::CFG_ROW_LENGTH,     8'd255, 1'b0, NO_RES},
        '{STEP_WRITE, set_pkg::CFG_FRAME_ROWS,     8'd255, 1'b0, NO_RES},
        '{STEP_PIXEL, set_pkg::CFG_FRAME_ROWS,     8'd0,   1'b1, '{8'd0, 8'd0, 1'b0, 1'b0}},
        '{STEP_PIXEL, set_pkg::CFG_FRAME_ROWS,     8'd255, 1'b1, '{8'd0, 8'd1, 1'b1, 1'b0}},
        '{STEP_PIXEL, set_pkg::CFG_FRAME_ROWS,     8'd99,  1'b1, '{8'd0, 8'd2, 1'b0, 1'b0}},
        '{STEP_PIXEL, set_pkg::CFG_FRAME_ROWS,     8'd100, 1'b1, '{8'd0, 8'd3, 1'b1, 1'b0}},
        '{STEP_PIXEL, set_pkg::CFG_FRAME_ROWS,     8'h55,  1'b1, '{8'd0, 8'd4, 1'b0, 1'b0}},
        '{STEP_PIXEL, set_pkg::CFG_FRAME_ROWS,     8'hAA,  1'b1, '{8'd0, 8'd5, 1'b1, 1'b0}},
        '{STEP_WRITE, set_pkg::CFG_EDGE_THRESHOLD, 8'd0,   1'b0, NO_RES},
        '{STEP_PIXEL, set_pkg::CFG_FRAME_ROWS,     8'd0,   1'b1, '{8'd0, 8'd6, 1'b1, 1'b0}},
        '{STEP_WRITE, set_pkg::CFG_EDGE_THRESHOLD, 8'd255, 1'b0, NO_RES},
        '{STEP_PIXEL, set_pkg::CFG_FRAME_ROWS,     8'd254, 1'b1, '{8'd0, 8'd7, 1'b0, 1'b0}},
        '{STEP_PIXEL, set_pkg::CFG_FRAME_ROWS,     8'd255, 1'b1, '{8'd0, 8'd8, 1'b1, 1'b0}},
        '{STEP_WRITE, set_pkg::CFG_ROW_LENGTH,     8'd0,   1'b0, NO_RES},
        '{STEP_WRITE, set_pkg::CFG_FRAME_ROWS,     8'd1,   1'b0, NO_RES},
        '{STEP_WRITE, set_pkg::CFG_EDGE_THRESHOLD, 8'd100, 1'b0, NO_RES},
        '{STEP_PIXEL, set_pkg::CFG_FRAME_ROWS,     8'd200, 1'b1, '{8'd0, 8'd9, 1'b1, 1'b0}},
        '{STEP_PIXEL, set_pkg::CFG_FRAME_ROWS,     8'd0,   1'b0, NO_RES},
        '{STEP_PIXEL, set_pkg::CFG_FRAME_ROWS,     8'd255, 1'b0, NO_RES},
        '{STEP_PIXEL, set_pkg::CFG_FRAME_ROWS,     8'd0,   1'b0, NO_RES},
        '{STEP_PIXEL, set_pkg::CFG_FRAME_ROWS,     8'd255, 1'b0, NO_RES},
        '{STEP_PIXEL, set_pkg::CFG_FRAME_ROWS,     8'd255, 1'b0, NO_RES},
        '{STEP_PIXEL, set_pkg::CFG_FRAME_ROWS,     8'd0,   1'b0, NO_RES},
        '{STEP_WRITE, set_pkg::CFG_ROW_LENGTH,     8'd2,   1'b0, NO_RES},
        '{STEP_WRITE, set_pkg::CFG_FRAME_ROWS,     8'd2,   1'b0, NO_RES},
        '{STEP_WRITE, set_pkg::CFG_EDGE_THRESHOLD, 8'd1,   1'b0, NO_RES}
    };

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic sobel_classify(input set_pkg::pixel_t p, output int n,
                                  output set_pkg::res_t first, output set_pkg::res_t second);
        int              nrows;
        int              ncols;
        int              r;
        int              c;
        int              gx;
        int              gy;
        int              mag2;
        int              lim;
        set_pkg::pixel_t top;
        set_pkg::pixel_t mid;
        set_pkg::res_t   found [2];
        logic            border;
        logic            frame_done;
        nrows = (rows_q < set_pkg::MIN_SIZE) ? int'(set_pkg::MIN_SIZE) : int'(rows_q);
        ncols = (cols_q < set_pkg::MIN_SIZE) ? int'(set_pkg::MIN_SIZE) : int'(cols_q);
        r = scan_row;
        c = scan_col;
        top = two_above[c];
        mid = one_above[c];
        found[0] = '0;
        found[1] = '0;
        n = 0;
        if (r >= 2 && c >= 2)
        begin
            gx = (int'(top) + 2 * int'(mid) + int'(p))
               - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
            gy = (int'(win[2]) + 2 * int'(win[5]) + int'(p))
               - (int'(win[0]) + 2 * int'(win[3]) + int'(top));
            mag2 = gx * gx + gy * gy;
            lim = int'(thresh_q) * int'(thresh_q);
            found[n] = '{set_pkg::pos_t'(r - 1), set_pkg::pos_t'(c - 1), mag2 >= lim, 1'b0};
            n++;
        end
        frame_done = (r + 1 >= nrows) && (c + 1 >= ncols);
        border = (r == 0) || (r + 1 >= nrows) || (c == 0) || (c + 1 >= ncols);
        if (border)
        begin
            found[n] = '{set_pkg::pos_t'(r), set_pkg::pos_t'(c), p >= thresh_q, frame_done};
            n++;
        end
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = p;
        two_above[c] = mid;
        one_above[c] = p;
        if (c + 1 >= ncols)
        begin
            scan_col = '0;
            scan_row = (r + 1 >= nrows) ? set_pkg::pos_t'(0) : set_pkg::pos_t'(r + 1);
        end
        else
        begin
            scan_col = set_pkg::pos_t'(c + 1);
        end
        first = found[0];
        second = found[1];
    endtask

    task automatic send_pixel(input set_pkg::pixel_t p, input logic typed,
                              input set_pkg::res_t want);
        int            gap;
        int            n;
        set_pkg::res_t a;
        set_pkg::res_t b;
        idle_stage = (pixels_sent * 3 / ITEM_TARGET > 2) ? 2 : pixels_sent * 3 / ITEM_TARGET;
        gap = 0;
        while (gap < 16 && $urandom_range(0, 99) < SEND_IDLE[idle_stage])
            gap++;
        if (gap > 0)
        begin
            @(negedge clk);
            pix.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pix.valid <= 1'b1;
        pix.pixel <= p;
        do
            @(posedge clk);
        while (!pix.ready);
        pixels_sent++;
        sobel_classify(p, n, a, b);
        if (typed)
            classified_q.push_back(want);
        else
        begin
            if (n > 0)
                classified_q.push_back(a);
            if (n > 1)
                classified_q.push_back(b);
        end
    endtask

    task automatic wait_drained;
        @(negedge clk);
        pix.valid <= 1'b0;
        while (classified_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input set_pkg::cfg_idx_t sel, input logic [7:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        case (sel)
            set_pkg::CFG_FRAME_ROWS:     rows_q = value;
            set_pkg::CFG_ROW_LENGTH:     cols_q = value;
            set_pkg::CFG_EDGE_THRESHOLD: thresh_q = value;
            default:                     ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Scan one frame to its wrap; optionally retune one register partway through.
    task automatic run_frame(input int cut, input set_pkg::cfg_idx_t mid_sel,
                             input logic [7:0] mid_val);
        int              style;
        int              level;
        int              count;
        int              q;
        set_pkg::pixel_t p;
        style = $urandom_range(0, 3);
        level = $urandom_range(0, 255);
        count = 0;
        do
        begin
            if (cut > 0 && count == cut)
            begin
                wait_drained;
                write_reg(mid_sel, mid_val);
            end
            case (style)
                0: p = set_pkg::pixel_t'($urandom_range(0, 255));
                1:
                begin
                    q = level + $urandom_range(0, 7);
                    p = (q > 255) ? 8'hFF : set_pkg::pixel_t'(q);
                end
                2: p = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                default: p = (scan_col[1] ^ scan_row[0]) ? set_pkg::pixel_t'(level)
                                                         : ~set_pkg::pixel_t'(level);
            endcase
            send_pixel(p, 1'b0, NO_RES);
            count++;
        end
        while (scan_row != 0 || scan_col != 0);
    endtask

    task automatic report_mismatch(input set_pkg::res_t want, input set_pkg::res_t got,
                                   input logic stray);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            if (stray)
                $display("unexpected result: row %0d col %0d edge %0d end %0d",
                         got.row, got.col, got.edge_res, got.frame_end);
            else
                $display("mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                         want.row, want.col, want.edge_res, want.frame_end,
                         got.row, got.col, got.edge_res, got.frame_end);
        end
    endtask

    always @(negedge clk)
    begin
        res.ready <= ($urandom_range(0, 99) >= RECV_IDLE[idle_stage]);
    end

    always @(posedge clk)
    begin : check_results
        set_pkg::res_t got;
        set_pkg::res_t want;
        if (rst_n && res.valid && res.ready)
        begin
            got = '{res.out_row, res.out_col, res.edge_res, res.frame_end};
            if (classified_q.size() == 0)
                report_mismatch(NO_RES, got, 1'b1);
            else
            begin
                want = classified_q.pop_front();
                if (got.row !== want.row || got.col !== want.col
                    || got.edge_res !== want.edge_res || got.frame_end !== want.frame_end)
                    report_mismatch(want, got, 1'b0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pix.valid && pix.ready) || (res.valid && res.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        set_pkg::cfg_idx_t sel;
        logic [7:0]        mid_val;
        logic [7:0]        t;
        int                cut;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pix.valid = 1'b0;
        pix.pixel = '0;
        res.ready = 1'b0;
        pixels_sent = 0;
        idle_stage = 0;
        mismatch_count = 0;
        stall_cycles = 0;
        scan_row = '0;
        scan_col = '0;
        rows_q = set_pkg::RST_FRAME_ROWS;
        cols_q = set_pkg::RST_ROW_LENGTH;
        thresh_q = set_pkg::RST_THRESHOLD;
        for (int i = 0; i < 256; i++)
        begin
            one_above[i] = '0;
            two_above[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            win[i] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_COUNT; i++)
        begin
            if (directed_rows[i].kind == STEP_WRITE)
            begin
                wait_drained;
                write_reg(directed_rows[i].sel, directed_rows[i].value);
            end
            else
                send_pixel(directed_rows[i].value, directed_rows[i].typed,
                           directed_rows[i].want);
        end

        // tall frame cut short from below, then a wide frame narrowed to three columns after its first full row
        wait_drained;
        write_reg(set_pkg::CFG_FRAME_ROWS, 8'd255);
        write_reg(set_pkg::CFG_ROW_LENGTH, 8'd3);
        run_frame(90, set_pkg::CFG_FRAME_ROWS, 8'd4);
        wait_drained;
        write_reg(set_pkg::CFG_FRAME_ROWS, 8'd3);
        write_reg(set_pkg::CFG_ROW_LENGTH, 8'd255);
        run_frame(255, set_pkg::CFG_ROW_LENGTH, 8'd3);

        while (pixels_sent < ITEM_TARGET)
        begin
            wait_drained;
            if ($urandom_range(0, 1) != 0)
                write_reg(set_pkg::CFG_FRAME_ROWS, ($urandom_range(0, 9) == 0)
                          ? 8'($urandom_range(10, 24)) : 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 1) != 0)
                write_reg(set_pkg::CFG_ROW_LENGTH, ($urandom_range(0, 11) == 0)
                          ? 8'($urandom_range(13, 48)) : 8'($urandom_range(0, 12)));
            if ($urandom_range(0, 1) != 0)
            begin
                case ($urandom_range(0, 3))
                    0:       t = 8'd0;
                    1:       t = 8'd255;
                    2:       t = 8'($urandom_range(0, 40));
                    default: t = 8'($urandom_range(0, 255));
                endcase
                write_reg(set_pkg::CFG_EDGE_THRESHOLD, t);
            end
            // widen columns only at a frame boundary; shrink or retune anything mid-frame
            case ($urandom_range(0, 2))
                0:
                begin
                    sel = set_pkg::CFG_FRAME_ROWS;
                    mid_val = 8'($urandom_range(0, 24));
                end
                1:
                begin
                    sel = set_pkg::CFG_ROW_LENGTH;
                    mid_val = 8'($urandom_range(0, cols_q));
                end
                default:
                begin
                    sel = set_pkg::CFG_EDGE_THRESHOLD;
                    mid_val = 8'($urandom_range(0, 255));
                end
            endcase
            cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
            run_frame(cut, sel, mid_val);
        end

        wait_drained;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && classified_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
